>>> rtl/name_match_filter_core_defines.svh
// Assertion macros shared by the name match filter checker.
`ifndef NAME_MATCH_FILTER_CORE_DEFINES_SVH
`define NAME_MATCH_FILTER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NMF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nmf_pkg.sv
// Shared types, codes and helpers for the name match filter.
`timescale 1ns / 1ps

package nmf_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int REC_W       = 24;
   localparam int NAME_LEN_W  = 16;
   localparam int CSR_W       = 24;

   localparam logic [NAME_LEN_W-1:0] NAME_LEN_MAX = 16'hFFFF;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] UPPER_Z     = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam logic CSR_MATCH_MODE = 1'b0;
   localparam logic CSR_MAX_HITS   = 1'b1;

   typedef enum logic [1:0] {
      OP_QUERY_BYTE = 2'd0,
      OP_CLEAR      = 2'd1,
      OP_NAME_BYTE  = 2'd2,
      OP_END_RECORD = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_SUBSTRING = 2'd0,
      MODE_PREFIX    = 2'd1,
      MODE_SUFFIX    = 2'd2,
      MODE_EXACT     = 2'd3
   } match_mode_type;

   typedef struct packed {
      logic query_wr;
      logic clear;
      logic name_byte;
      logic prefix_eval;
      logic end_item;
      logic scan_start;
      logic scan_step;
      logic sub_commit;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic name_needs_scan;
      logic end_needs_scan;
      logic scan_done;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= UPPER_A && b <= UPPER_Z) r = b + CASE_OFFSET;
      return r;
   endfunction

endpackage

>>> rtl/nmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nmf_ctrl.sv
// Sequencing state machine of the name match filter.
`timescale 1ns / 1ps

module nmf_ctrl import nmf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_opcode,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_PREFIX    = 5'b00010,
      ST_SCAN_NAME = 5'b00100,
      ST_SCAN_END  = 5'b01000,
      ST_FINISH    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (opcode_type'(req_opcode))
                  OP_QUERY_BYTE: cmd.query_wr = 1'b1;
                  OP_CLEAR:      cmd.clear = 1'b1;
                  OP_NAME_BYTE: begin
                     cmd.name_byte = 1'b1;
                     state_in      = ST_PREFIX;
                  end
                  OP_END_RECORD: begin
                     cmd.end_item = 1'b1;
                     if (status.end_needs_scan) begin
                        cmd.scan_start = 1'b1;
                        state_in       = ST_SCAN_END;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
               endcase
            end
         end
         ST_PREFIX: begin
            cmd.prefix_eval = 1'b1;
            if (status.name_needs_scan) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN_NAME;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_NAME: begin
            if (status.scan_done) begin
               cmd.sub_commit = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SCAN_END: begin
            if (status.scan_done) state_in = ST_FINISH;
            else cmd.scan_step = 1'b1;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

>>> rtl/nmf_dpath.sv
// Datapath: query and name window memories, record state, tail scan, result register.
`timescale 1ns / 1ps

module nmf_dpath import nmf_pkg::*; #(
   parameter int QUERY_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_byte,
   input  logic             req_dead,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             rsp_tready,
   input  ctrl_cmd_type     cmd,
   output dp_status_type    status,
   output logic             rsp_valid,
   output logic [REC_W-1:0] rsp_index,
   output logic             rsp_hit,
   output logic             rsp_limit
);

   localparam int AW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
   localparam int LW = $clog2(QUERY_MAX + 1);
   localparam logic [LW-1:0] QMAX  = LW'(QUERY_MAX);
   localparam logic [AW-1:0] ALAST = AW'(QUERY_MAX - 1);

   match_mode_type   mode_ff, mode_in;
   logic [REC_W-1:0] max_hits_ff, max_hits_in;

   logic [LW-1:0]         qlen_ff, qlen_in;
   logic [NAME_LEN_W-1:0] nl_ff, nl_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic                  prefix_ok_ff, prefix_ok_in;
   logic                  sub_found_ff, sub_found_in;
   logic [REC_W-1:0]      rec_cnt_ff, rec_cnt_in;
   logic [REC_W-1:0]      hit_cnt_ff, hit_cnt_in;

   logic [7:0]    byte_ff, byte_in;
   logic          pchk_ff, pchk_in;
   logic          dead_ff, dead_in;
   logic          tail_ok_ff, tail_ok_in;
   logic [LW-1:0] issue_ff, issue_in;
   logic [LW-1:0] cmp_ff, cmp_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic          rd_valid_ff, rd_valid_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [REC_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic             rsp_limit_ff, rsp_limit_in;

   logic [NAME_LEN_W-1:0] qlen_ext;
   logic                  qlen_full;
   logic [LW:0]           a0_sum;
   logic [AW-1:0]         a0;
   logic                  issue_more;
   logic [7:0]            q_rd_data, w_rd_data;
   logic [AW-1:0]         q_rd_addr;
   logic                  match;
   logic                  hit_now;
   logic [REC_W-1:0]      hit_cnt_next;

   assign qlen_ext   = NAME_LEN_W'(qlen_ff);
   assign qlen_full  = (qlen_ff == QMAX);
   assign issue_more = (issue_ff < qlen_ff);
   assign q_rd_addr  = cmd.scan_step ? issue_ff[AW-1:0] : nl_ff[AW-1:0];

   // oldest byte of the tail window sits qlen entries behind the write pointer
   assign a0_sum = (LW+1)'(wp_ff) + (LW+1)'(QUERY_MAX) - (LW+1)'(qlen_ff);
   assign a0     = (a0_sum >= (LW+1)'(QUERY_MAX)) ?
                   AW'(a0_sum - (LW+1)'(QUERY_MAX)) : AW'(a0_sum);

   nmf_ram #(.WIDTH(8), .DEPTH(QUERY_MAX)) u_query_ram (
      .clock   (clock),
      .wr_en   (cmd.query_wr && !qlen_full),
      .wr_addr (qlen_ff[AW-1:0]),
      .wr_data (fold_case(req_byte)),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   nmf_ram #(.WIDTH(8), .DEPTH(QUERY_MAX)) u_window_ram (
      .clock   (clock),
      .wr_en   (cmd.name_byte),
      .wr_addr (wp_ff),
      .wr_data (req_byte),
      .rd_addr (wa_ff),
      .rd_data (w_rd_data)
   );

   always_comb begin
      unique case (mode_ff)
         MODE_SUBSTRING: match = sub_found_ff || (qlen_ff == '0);
         MODE_PREFIX:    match = prefix_ok_ff && (nl_ff >= qlen_ext);
         MODE_SUFFIX:    match = tail_ok_ff;
         MODE_EXACT:     match = prefix_ok_ff && (nl_ff == qlen_ext);
      endcase
      hit_now      = !dead_ff && (hit_cnt_ff < max_hits_ff) && match;
      hit_cnt_next = hit_now ? hit_cnt_ff + 1'b1 : hit_cnt_ff;
   end

   assign status.name_needs_scan = (qlen_ff != '0) && (nl_ff >= qlen_ext) && !sub_found_ff;
   assign status.end_needs_scan  = (mode_ff == MODE_SUFFIX) && (qlen_ff != '0) &&
                                   (nl_ff >= qlen_ext);
   assign status.scan_done       = (cmp_ff == qlen_ff) || !tail_ok_ff;
   assign status.rsp_busy        = rsp_valid_ff && !rsp_tready;

   always_comb begin
      mode_in     = mode_ff;
      max_hits_in = max_hits_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATCH_MODE: mode_in = match_mode_type'(csr_wdata[1:0]);
            CSR_MAX_HITS:   max_hits_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      qlen_in      = qlen_ff;
      nl_in        = nl_ff;
      wp_in        = wp_ff;
      prefix_ok_in = prefix_ok_ff;
      sub_found_in = sub_found_ff;
      rec_cnt_in   = rec_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      byte_in      = byte_ff;
      pchk_in      = pchk_ff;
      dead_in      = dead_ff;
      tail_ok_in   = tail_ok_ff;
      issue_in     = issue_ff;
      cmp_in       = cmp_ff;
      wa_in        = wa_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_limit_in = rsp_limit_ff;

      if (cmd.query_wr && !qlen_full) qlen_in = qlen_ff + 1'b1;

      if (cmd.clear) begin
         qlen_in      = '0;
         rec_cnt_in   = '0;
         hit_cnt_in   = '0;
         nl_in        = '0;
         wp_in        = '0;
         prefix_ok_in = 1'b1;
         sub_found_in = 1'b0;
      end

      if (cmd.name_byte) begin
         byte_in = req_byte;
         pchk_in = (nl_ff < qlen_ext);
         if (nl_ff != NAME_LEN_MAX) nl_in = nl_ff + 1'b1;
         wp_in = (wp_ff == ALAST) ? '0 : wp_ff + 1'b1;
      end

      // query byte at the old name length was read during the accept cycle
      if (cmd.prefix_eval && pchk_ff && (byte_ff != q_rd_data)) prefix_ok_in = 1'b0;

      if (cmd.end_item) begin
         dead_in    = req_dead;
         tail_ok_in = (qlen_ff == '0);
      end

      if (cmd.scan_start) begin
         tail_ok_in = 1'b1;
         issue_in   = '0;
         cmp_in     = '0;
         wa_in      = a0;
      end

      // one byte pair read per cycle, compared in the cycle after
      if (cmd.scan_step) begin
         rd_valid_in = issue_more;
         if (issue_more) begin
            issue_in = issue_ff + 1'b1;
            wa_in    = (wa_ff == ALAST) ? '0 : wa_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            cmp_in = cmp_ff + 1'b1;
            if (q_rd_data != w_rd_data) tail_ok_in = 1'b0;
         end
      end

      if (cmd.sub_commit && tail_ok_ff) sub_found_in = 1'b1;

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = rec_cnt_ff;
         rsp_hit_in   = hit_now;
         rsp_limit_in = (hit_cnt_next >= max_hits_ff);
         hit_cnt_in   = hit_cnt_next;
         rec_cnt_in   = rec_cnt_ff + 1'b1;
         nl_in        = '0;
         wp_in        = '0;
         prefix_ok_in = 1'b1;
         sub_found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SUBSTRING;
         max_hits_ff  <= '1;
         qlen_ff      <= '0;
         nl_ff        <= '0;
         wp_ff        <= '0;
         prefix_ok_ff <= 1'b1;
         sub_found_ff <= 1'b0;
         rec_cnt_ff   <= '0;
         hit_cnt_ff   <= '0;
         tail_ok_ff   <= 1'b0;
         issue_ff     <= '0;
         cmp_ff       <= '0;
         wa_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         max_hits_ff  <= max_hits_in;
         qlen_ff      <= qlen_in;
         nl_ff        <= nl_in;
         wp_ff        <= wp_in;
         prefix_ok_ff <= prefix_ok_in;
         sub_found_ff <= sub_found_in;
         rec_cnt_ff   <= rec_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         tail_ok_ff   <= tail_ok_in;
         issue_ff     <= issue_in;
         cmp_ff       <= cmp_in;
         wa_ff        <= wa_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      pchk_ff      <= pchk_in;
      dead_ff      <= dead_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_limit = rsp_limit_ff;

endmodule

>>> rtl/name_match_filter_core.sv
// Top level of the name match filter: controller, datapath and port packing.
// One beat at a time: query and clear beats stay in the idle state; an end beat goes
//   to the finish state, after a tail scan when suffix mode needs one, and its response
//   is registered once the result register is free. A name byte passes the prefix state,
//   then a tail scan if one runs, bounded by the one read port of each byte memory.
// Reset (synchronous): empty query, counters zero, match_mode 0, max_hits all ones.
`timescale 1ns / 1ps

module name_match_filter_core import nmf_pkg::*; #(
   parameter int QUERY_MAX = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request beats
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] data_byte, [8] record_dead, rest 0
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // [1:0] opcode
   // response beats
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [23:0] record_index, [24] hit,
                                              // [25] limit_reached, rest 0
   // register writes
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   ctrl_cmd_type     cmd;
   dp_status_type    status;
   logic [REC_W-1:0] rsp_index;
   logic             rsp_hit;
   logic             rsp_limit;

   // controller owns the handshake; everything it does goes out as commands
   nmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath holds the query, the name window (circular), and the result
   // register that decouples the response side from the request side
   nmf_dpath #(.QUERY_MAX(QUERY_MAX)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata[7:0]),
      .req_dead   (req_tdata[8]),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_hit    (rsp_hit),
      .rsp_limit  (rsp_limit)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-REC_W-2){1'b0}}, rsp_limit, rsp_hit, rsp_index};

endmodule

>>> rtl/nmf_checker.sv
// Port-level checks for the name match filter, bound to the top level.
`timescale 1ns / 1ps
`include "name_match_filter_core_defines.svh"

module nmf_checker import nmf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `NMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response beat changed")
   `NMF_ASSERT_NEXT(a_name_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_NAME_BYTE, !req_tready, "name byte did not hold off the next beat")
   `NMF_ASSERT_NEXT(a_end_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_END_RECORD, !req_tready, "end beat did not hold off the next beat")
   `NMF_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "response appeared without an end beat in progress")

endmodule

bind name_match_filter_core nmf_checker u_nmf_checker (.*);

>>> bench/name_match_filter_checker.sv
// Response predictor and comparator for the name match filter.
`timescale 1ns / 1ps

module name_match_filter_checker import nmf_pkg::*; #(
   parameter int QUERY_MAX = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   localparam logic [7:0] CAP_A    = 8'h41;
   localparam logic [7:0] CAP_Z    = 8'h5A;
   localparam int         NAME_SAT = 65535;

   typedef struct packed {
      logic [REC_W-1:0] index;
      logic             hit;
      logic             limit;
   } record_outcome_type;

   record_outcome_type outcome_q [$];

   match_mode_type   mode;
   logic [CSR_W-1:0] hit_limit;
   logic [7:0]       query_bytes [QUERY_MAX];
   int               query_len;
   logic [7:0]       recent [QUERY_MAX];   // newest name byte at 0
   int               name_count;
   bit               prefix_good;
   bit               found;
   logic [REC_W-1:0] rec_idx;
   logic [REC_W-1:0] hits;
   int               fails = 0;

   // newest query_len name bytes equal the query
   function automatic bit tail_equal();
      if (name_count < query_len) return 1'b0;
      for (int j = 0; j < query_len; j++)
         if (recent[query_len-1-j] != query_bytes[j]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic forget_name();
      foreach (recent[i]) recent[i] = 8'h00;
      name_count  = 0;
      prefix_good = 1'b1;
      found       = 1'b0;
   endtask

   task automatic absorb_beat(input opcode_type op, input logic [7:0] b, input logic dead);
      logic [7:0]         v;
      bit                 match;
      record_outcome_type res;
      case (op)
         OP_QUERY_BYTE: begin
            if (query_len < QUERY_MAX) begin
               v = b;
               if (v >= CAP_A && v <= CAP_Z) v = v + 8'h20;
               query_bytes[query_len] = v;
               query_len++;
            end
         end
         OP_CLEAR: begin
            query_len = 0;
            rec_idx   = '0;
            hits      = '0;
            forget_name();
         end
         OP_NAME_BYTE: begin
            if (name_count < query_len && b != query_bytes[name_count]) prefix_good = 1'b0;
            for (int i = QUERY_MAX - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = b;
            if (name_count < NAME_SAT) name_count++;
            if (query_len > 0 && tail_equal()) found = 1'b1;
         end
         default: begin
            case (mode)
               MODE_SUBSTRING: match = found || query_len == 0;
               MODE_PREFIX:    match = prefix_good && name_count >= query_len;
               MODE_SUFFIX:    match = tail_equal();
               default:        match = prefix_good && name_count == query_len;
            endcase
            res.index = rec_idx;
            res.hit   = 1'b0;
            if (!dead && hits < hit_limit && match) begin
               res.hit = 1'b1;
               hits    = hits + 1'b1;
            end
            res.limit = (hits >= hit_limit);
            outcome_q.push_back(res);
            rec_idx = rec_idx + 1'b1;
            forget_name();
         end
      endcase
   endtask

   always @(posedge clock) begin
      record_outcome_type got;
      record_outcome_type want;
      if (reset) begin
         mode      = MODE_SUBSTRING;
         hit_limit = '1;
         query_len = 0;
         rec_idx   = '0;
         hits      = '0;
         forget_name();
         outcome_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MATCH_MODE) mode = match_mode_type'(csr_wdata[1:0]);
            else hit_limit = csr_wdata;
         end
         // responses never belong to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[REC_W-1:0];
            got.hit   = rsp_tdata[REC_W];
            got.limit = rsp_tdata[REC_W+1];
            if (outcome_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected response beat: index %0d hit %0b limit %0b",
                           $realtime, got.index, got.hit, got.limit);
            end else begin
               want = outcome_q.pop_front();
               if (got != want) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: response mismatch: expected index %0d hit %0b limit %0b, got index %0d hit %0b limit %0b",
                              $realtime, want.index, want.hit, want.limit,
                              got.index, got.hit, got.limit);
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_beat(opcode_type'(req_tuser[1:0]), req_tdata[7:0], req_tdata[8]);
      end
      outstanding <= outcome_q.size();
      fail_count  <= fails;
   end

endmodule

>>> bench/name_match_filter_core_tb.sv
// Testbench top for the name match filter: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module name_match_filter_core_tb;
   import nmf_pkg::*;

   localparam int QUERY_MAX       = 64;
   // a name beat may still run a tail check after the last response is out,
   // so register writes wait this long on top
   localparam int SETTLE_CYCLES   = QUERY_MAX + 16;
   // slowest quiet stretch is a settle wait plus one long tail check and
   // worst-case gaps on both sides
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_BEATS    = 1820;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // [7:0] data_byte, [8] record_dead
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;  // [1:0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [23:0] record_index, [24] hit, [25] limit_reached
   logic                   csr_wr_en  = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [CSR_W-1:0]       csr_wdata  = '0;

   int fail_count;
   int outstanding;

   bit no_idle     = 1'b0;   // set for bursts without gaps or stalls
   int beats_sent  = 0;
   int rsp_beats   = 0;
   int rsp_hits    = 0;
   int quiet_cycles = 0;

   logic [7:0] query_copy [$];  // folded query as the block should hold it

   // byte corners: case-fold bounds, their neighbors, zero and all ones
   logic [7:0] corner_query [6] = '{8'h41, 8'h5A, 8'h00, 8'hFF, 8'h40, 8'h5B};
   logic [7:0] corner_name  [6] = '{8'h61, 8'h7A, 8'h00, 8'hFF, 8'h40, 8'h5B};

   always #5 clock = ~clock;

   name_match_filter_core #(.QUERY_MAX(QUERY_MAX)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   name_match_filter_checker #(.QUERY_MAX(QUERY_MAX)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int draw_wait();
      return no_idle ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic logic [7:0] lower_case(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
   endfunction

   // 0: any byte, 1: a/A/b/B (upper case never matches in a name), 2: a/b
   function automatic logic [7:0] pick_byte(input int alpha);
      int sel;
      sel = $urandom_range(0, 3);
      case (alpha)
         0:       return 8'($urandom_range(0, 255));
         1:       return sel[1] ? (sel[0] ? 8'h42 : 8'h62) : (sel[0] ? 8'h41 : 8'h61);
         default: return sel[0] ? 8'h61 : 8'h62;
      endcase
   endfunction

   // Valid is only lowered when a gap follows, so back-to-back beats never
   // see two assignments to req_tvalid in one step.
   task automatic send_beat(input opcode_type op, input logic [7:0] b, input logic dead);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-9){1'b0}}, dead, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic load_query_byte(input logic [7:0] b);
      send_beat(OP_QUERY_BYTE, b, 1'($urandom_range(0, 1)));
      if (query_copy.size() < QUERY_MAX) query_copy.push_back(lower_case(b));
   endtask

   task automatic send_name(input logic [7:0] b);
      send_beat(OP_NAME_BYTE, b, 1'($urandom_range(0, 1)));
   endtask

   task automatic issue_clear();
      send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      query_copy.delete();
   endtask

   // Stop sending, wait for every predicted response, then let the block
   // finish any tail check still running.
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_config(input match_mode_type mode, input logic [CSR_W-1:0] lim);
      wait_idle(SETTLE_CYCLES);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MATCH_MODE;
      csr_wdata <= CSR_W'(mode);
      @(posedge clock);
      csr_index <= CSR_MAX_HITS;
      csr_wdata <= lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Response side: a fresh stall draw for every beat.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         rsp_beats++;
         if (rsp_tdata[REC_W]) rsp_hits++;
      end
   end

   // Watchdog: any beat on either channel or a register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int         sess;
      int         random_start;
      int         n_q;
      int         n_rec;
      int         kind;
      int         head;
      int         tail;
      int         alpha;
      int         qsize;
      bit         long_q;
      logic [7:0] b;
      logic [CSR_W-1:0] lim;
      opcode_type op;

      sess = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset config is substring mode, no hit limit ----
      // empty query matches an empty live record; junk data on an end beat
      send_beat(OP_END_RECORD, 8'hFF, 1'b0);
      issue_clear();
      // query corners: A and Z fold, their neighbors and 00/FF stay as given
      foreach (corner_query[i]) load_query_byte(corner_query[i]);
      foreach (corner_name[i]) send_name(corner_name[i]);
      send_beat(OP_END_RECORD, 8'h00, 1'b1);     // dead record: no hit
      foreach (corner_name[i]) send_name(corner_name[i]);
      send_beat(OP_END_RECORD, 8'hA5, 1'b0);     // live copy: hit
      wait_idle(0);                              // hold off until all responses are in

      // ---- exact mode with an empty query ----
      set_config(MODE_EXACT, '1);
      issue_clear();
      send_beat(OP_END_RECORD, 8'h00, 1'b0);     // empty name equals empty query

      // ---- random sessions: config, query load, then a run of records ----
      random_start = beats_sent;
      while (beats_sent < random_start + RANDOM_BEATS) begin
         sess++;
         long_q  = (sess % 9 == 4);              // overflowing query now and then
         no_idle = ($urandom_range(0, 4) == 0);
         alpha   = $urandom_range(0, 2);
         case ($urandom_range(0, 7))
            0:       lim = '0;
            1:       lim = CSR_W'($urandom_range(1, 4));
            2:       lim = '1;
            default: lim = CSR_W'($urandom_range(5, 5000));
         endcase
         set_config(match_mode_type'($urandom_range(0, 3)), lim);

         // occasional burst of arbitrary beats
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               op = opcode_type'($urandom_range(0, 3));
               if (op == OP_QUERY_BYTE)  load_query_byte(pick_byte(0));
               else if (op == OP_CLEAR)  issue_clear();
               else send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         end

         if ($urandom_range(0, 3) != 0) issue_clear();
         if (long_q)                          n_q = $urandom_range(60, 70);
         else if ($urandom_range(0, 9) == 0)  n_q = 0;
         else                                 n_q = $urandom_range(1, 6);
         repeat (n_q) load_query_byte(pick_byte(alpha));

         n_rec = long_q ? 3 : $urandom_range(3, 12);
         repeat (n_rec) begin
            // 0 exact, 1 prefix, 2 suffix, 3 inside, 4 last byte redrawn,
            // 5 random bytes, 6 empty
            kind = $urandom_range(0, 6);
            head = $urandom_range(0, 4);
            tail = $urandom_range(0, 4);
            if (kind == 2 || kind == 3 || kind == 5)
               repeat (head) send_name(pick_byte(alpha));
            case ($urandom_range(0, 24))
               0:       load_query_byte(pick_byte(alpha));  // query grows mid-record
               1:       issue_clear();
               2:       wait_idle(0);
               default: ;
            endcase
            if (kind <= 4) begin
               qsize = query_copy.size();
               for (int i = 0; i < qsize; i++) begin
                  b = query_copy[i];
                  if (kind == 4 && i == qsize - 1) b = pick_byte(alpha);
                  send_name(b);
               end
            end
            if (kind == 1 || kind == 3 || kind == 5)
               repeat (tail) send_name(pick_byte(alpha));
            send_beat(OP_END_RECORD, 8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
            if ($urandom_range(0, 15) == 0) wait_idle(0);
         end
      end

      no_idle = 1'b0;
      wait_idle(SETTLE_CYCLES);
      $display("Ran %0d request beats: corner bytes, an empty exact record, %0d random sessions.",
               beats_sent, sess);
      $display("Checked %0d responses (%0d hits) over all match modes and hit limits 0 to max.",
               rsp_beats, rsp_hits);
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
